### rtl/core/sigma_outlier_counter_macros.svh
// Assertion macros for the sigma outlier counter.
// Needs clock and reset in the scope of the file that includes it.
`ifndef SIGMA_OUTLIER_COUNTER_MACROS_SVH
`define SIGMA_OUTLIER_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SOC_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
`define SOC_ASSERT_NXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define SOC_ASSERT_IMP(name, pre, post, msg)
`define SOC_ASSERT_NXT(name, pre, post, msg)
`endif

`endif

### rtl/core/soc_pkg.sv
// Shared constants and types of the sigma outlier counter.
// No dependencies.
`timescale 1ns / 1ps

package soc_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int SAMPLE_BITS = 24;
   localparam int SAMPLE_W    = 24;
   localparam int CNT_W       = 11;
   localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SEXT_SHIFT  = SAMPLE_W - SAMPLE_BITS;

   // accumulator and datapath widths
   localparam int SUM_W   = 34;
   localparam int SQS_W   = 57;
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 69;
   localparam int LIM_W   = 71;
   localparam int DIF_W   = 36;
   localparam int MAG_W   = 35;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CNT_W-1:0]           count_type;

endpackage

### rtl/core/soc_if.sv
// Request and response channel interfaces of the sigma outlier counter.
// Depends on soc_pkg.
`timescale 1ns / 1ps

interface soc_req_if;
   logic                   valid;
   logic                   ready;
   soc_pkg::sample_type    sample;
   logic                   last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface soc_rsp_if;
   logic                   valid;
   logic                   ready;
   soc_pkg::count_type     outlier_count;
   logic                   overflowed;

   modport source (output valid, output outlier_count, output overflowed, input ready);
   modport sink (input valid, input outlier_count, input overflowed, output ready);
endinterface

### rtl/core/soc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module soc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/sigma_outlier_counter.sv
// Sigma outlier counter: counts samples beyond three sigma of a set's mean.
// Each stored request is stored and accumulated, then squared on the shared 36x24
// multiplier. After the last request the setup states run, then RD, NX, DIF, DM0, DM1
// and CMP per stored sample, and FIN loads the response; one set is processed at a time.
// Synchronous reset clears control and accumulators; the sample store is not cleared.
// Depends on soc_pkg, soc_if, soc_ram and sigma_outlier_counter_macros.svh.
`timescale 1ns / 1ps
`include "sigma_outlier_counter_macros.svh"

module sigma_outlier_counter (
   input  logic       clock,
   input  logic       reset,
   soc_req_if.sink    req_chan,
   soc_rsp_if.source  rsp_chan
);

   localparam int SW  = soc_pkg::SAMPLE_W;
   localparam int CW  = soc_pkg::CNT_W;
   localparam int AW  = soc_pkg::MUL_A_W;
   localparam int BW  = soc_pkg::MUL_B_W;
   localparam int PW  = soc_pkg::PROD_W;
   localparam int XW  = soc_pkg::ACC_W;
   localparam int LW  = soc_pkg::LIM_W;
   localparam int DW  = soc_pkg::DIF_W;
   localparam int MW  = soc_pkg::MAG_W;
   localparam int UW  = soc_pkg::SUM_W;
   localparam int QW  = soc_pkg::SQS_W;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SQ   = 5'd1;
   localparam logic [4:0] ST_QADD = 5'd2;
   localparam logic [4:0] ST_NQ0  = 5'd3;
   localparam logic [4:0] ST_NQ1  = 5'd4;
   localparam logic [4:0] ST_SS0  = 5'd5;
   localparam logic [4:0] ST_SS1  = 5'd6;
   localparam logic [4:0] ST_VAR  = 5'd7;
   localparam logic [4:0] ST_LIM  = 5'd8;
   localparam logic [4:0] ST_LIM2 = 5'd9;
   localparam logic [4:0] ST_RD   = 5'd10;
   localparam logic [4:0] ST_NX   = 5'd11;
   localparam logic [4:0] ST_DIF  = 5'd12;
   localparam logic [4:0] ST_DM0  = 5'd13;
   localparam logic [4:0] ST_DM1  = 5'd14;
   localparam logic [4:0] ST_CMP  = 5'd15;
   localparam logic [4:0] ST_FIN  = 5'd16;

   logic [4:0]             state_ff, state_in;
   soc_pkg::count_type     count_ff, count_in;
   soc_pkg::count_type     idx_ff, idx_in;
   soc_pkg::count_type     hits_ff, hits_in;
   logic signed [UW-1:0]   sum_ff, sum_in;
   logic [QW-1:0]          sqsum_ff, sqsum_in;
   logic                   ovf_ff, ovf_in;
   logic                   last_ff, last_in;
   logic                   sq_pend_ff, sq_pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SW-1:0]          xmag_ff, xmag_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [XW-1:0]          acc_ff, acc_in;
   logic [XW-1:0]          var_ff, var_in;
   logic [LW-1:0]          lim_ff, lim_in;
   logic                   neg_ff, neg_in;
   logic [MW-1:0]          mag_ff, mag_in;
   soc_pkg::count_type     rsp_count_ff, rsp_count_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic [AW-1:0]          mul_a;
   logic [BW-1:0]          mul_b;

   soc_pkg::sample_type    sample_x;
   logic [SW-1:0]          x_mag;
   soc_pkg::sample_type    rd_data;
   logic [SW-1:0]          rd_mag;
   logic [UW-1:0]          sum_abs;
   logic                   accepted;
   logic                   room;
   logic                   fin_go;
   logic                   wr_en;

   logic [PW+AW-1:0]       prod_hi_a;
   logic [PW+BW-1:0]       prod_hi_b;
   logic [XW-1:0]          prod_lo;
   logic [XW:0]            var_diff;
   logic [XW-1:0]          sq_tot;
   logic [XW+2:0]          lim_sum;
   logic signed [DW-1:0]   dif_p;
   logic signed [DW-1:0]   dif_s;
   logic signed [DW-1:0]   dif_t;
   logic [DW-1:0]          dif_abs;
   soc_pkg::count_type     idx_next;

   soc_ram #(
      .WIDTH (SW),
      .DEPTH (soc_pkg::MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[soc_pkg::ADDR_W-1:0]),
      .wr_data (sample_x),
      .rd_addr (idx_ff[soc_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.outlier_count = rsp_count_ff;
   assign rsp_chan.overflowed    = rsp_ovf_ff;

   assign accepted = req_chan.valid && req_chan.ready;
   assign room     = (count_ff < soc_pkg::MAX_SAMPLES);
   assign fin_go   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);
   assign wr_en    = accepted && room;

   assign sample_x = (req_chan.sample <<< soc_pkg::SEXT_SHIFT) >>> soc_pkg::SEXT_SHIFT;
   assign x_mag    = sample_x[SW-1] ? $unsigned(-sample_x) : $unsigned(sample_x);
   assign rd_mag   = rd_data[SW-1] ? $unsigned(-rd_data) : $unsigned(rd_data);
   assign sum_abs  = sum_ff[UW-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);

   // shared multiplier
   assign prod_in  = mul_a * mul_b;

   assign prod_hi_a = {prod_ff, {AW{1'b0}}};
   assign prod_hi_b = {prod_ff, {BW{1'b0}}};
   assign prod_lo   = {{(XW-PW){1'b0}}, prod_ff};
   assign var_diff  = {1'b0, var_ff} - {1'b0, acc_ff};
   assign sq_tot    = acc_ff + prod_hi_b[XW-1:0];
   assign lim_sum   = {var_ff, 3'b000} + {3'b000, var_ff};
   assign idx_next  = idx_ff + 1'b1;

   // n*|x| -/+ S; magnitude is the same whichever sign x had
   assign dif_p   = $signed(prod_ff[DW-1:0]);
   assign dif_s   = {{(DW-UW){sum_ff[UW-1]}}, sum_ff};
   assign dif_t   = neg_ff ? (dif_p + dif_s) : (dif_p - dif_s);
   assign dif_abs = dif_t[DW-1] ? $unsigned(-dif_t) : $unsigned(dif_t);

   always_comb begin
      mul_a = {{(AW-SW){1'b0}}, xmag_ff};
      mul_b = xmag_ff;
      unique case (state_ff)
         ST_NQ0: begin
            mul_a = sqsum_ff[AW-1:0];
            mul_b = {{(BW-CW){1'b0}}, count_ff};
         end
         ST_NQ1: begin
            mul_a = {{(AW-(QW-AW)){1'b0}}, sqsum_ff[QW-1:AW]};
            mul_b = {{(BW-CW){1'b0}}, count_ff};
         end
         ST_SS0: begin
            mul_a = {{(AW-UW){1'b0}}, sum_abs};
            mul_b = sum_abs[BW-1:0];
         end
         ST_SS1: begin
            mul_a = {{(AW-UW){1'b0}}, sum_abs};
            mul_b = {{(BW-(UW-BW)){1'b0}}, sum_abs[UW-1:BW]};
         end
         ST_NX: begin
            mul_a = {{(AW-SW){1'b0}}, rd_mag};
            mul_b = {{(BW-CW){1'b0}}, count_ff};
         end
         ST_DM0: begin
            mul_a = {{(AW-MW){1'b0}}, mag_ff};
            mul_b = mag_ff[BW-1:0];
         end
         ST_DM1: begin
            mul_a = {{(AW-MW){1'b0}}, mag_ff};
            mul_b = {{(BW-(MW-BW)){1'b0}}, mag_ff[MW-1:BW]};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      hits_in      = hits_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      xmag_in      = xmag_ff;
      acc_in       = acc_ff;
      var_in       = var_ff;
      lim_in       = lim_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sq_pend_in   = (state_ff == ST_SQ);

      // square of the previous request is added in the cycle after its multiply
      if (sq_pend_ff) begin
         sqsum_in = sqsum_ff + prod_ff[QW-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               if (room) begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + {{(UW-SW){sample_x[SW-1]}}, sample_x};
                  xmag_in  = x_mag;
                  last_in  = req_chan.last;
                  state_in = ST_SQ;
               end else begin
                  ovf_in = 1'b1;
                  if (req_chan.last) begin
                     state_in = ST_NQ0;
                  end
               end
            end
         end
         ST_SQ: begin
            state_in = last_ff ? ST_QADD : ST_IDLE;
         end
         ST_QADD: begin
            state_in = ST_NQ0;
         end
         ST_NQ0: begin
            hits_in  = '0;
            state_in = ST_NQ1;
         end
         ST_NQ1: begin
            acc_in   = prod_lo;
            state_in = ST_SS0;
         end
         ST_SS0: begin
            var_in   = acc_ff + prod_hi_a[XW-1:0];
            state_in = ST_SS1;
         end
         ST_SS1: begin
            acc_in   = prod_lo;
            state_in = ST_VAR;
         end
         ST_VAR: begin
            acc_in   = sq_tot;
            state_in = ST_LIM;
         end
         ST_LIM: begin
            idx_in = '0;
            // small set or no spread: no outliers
            if ((count_ff < 2) || var_diff[XW] || (var_diff == '0)) begin
               state_in = ST_FIN;
            end else begin
               var_in   = var_diff[XW-1:0];
               state_in = ST_LIM2;
            end
         end
         ST_LIM2: begin
            lim_in   = lim_sum[LW-1:0];
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_NX;
         end
         ST_NX: begin
            neg_in   = rd_data[SW-1];
            state_in = ST_DIF;
         end
         ST_DIF: begin
            mag_in   = dif_abs[MW-1:0];
            state_in = ST_DM0;
         end
         ST_DM0: begin
            state_in = ST_DM1;
         end
         ST_DM1: begin
            acc_in   = prod_lo;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ({{(LW-XW){1'b0}}, sq_tot} > lim_ff) begin
               hits_in = hits_ff + 1'b1;
            end
            idx_in   = idx_next;
            state_in = (idx_next == count_ff) ? ST_FIN : ST_RD;
         end
         ST_FIN: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = hits_ff;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               sum_in       = '0;
               sqsum_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         hits_ff      <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         sq_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         hits_ff      <= hits_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         sq_pend_ff   <= sq_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xmag_ff      <= xmag_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      var_ff       <= var_in;
      lim_ff       <= lim_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   `SOC_ASSERT_IMP(a_count_cap, 1'b1, count_ff <= soc_pkg::MAX_SAMPLES, "sample count over capacity")
   `SOC_ASSERT_IMP(a_idx_in_set, state_ff == ST_RD, idx_ff < count_ff, "read beyond stored set")
   `SOC_ASSERT_IMP(a_hits_bound, state_ff == ST_CMP, hits_ff <= idx_ff, "hit count exceeds scanned")
   `SOC_ASSERT_NXT(a_fin_clear, fin_go, (count_ff == '0) && rsp_valid_ff, "set not cleared on finish")

endmodule

### sim/sigma_outlier_counter_checker.sv
// Checker for the sigma outlier counter: watches both channels, predicts the
// outlier count and overflow flag of every finished set and compares them with each response.
// Depends on soc_pkg and soc_if.
`timescale 1ns / 1ps

module sigma_outlier_counter_checker (
   input  logic clock,
   input  logic reset,
   soc_req_if   req_mon,
   soc_rsp_if   rsp_mon,
   output int   failures,
   output int   pending
);

   typedef struct packed {
      soc_pkg::count_type outlier_count;
      logic               overflowed;
   } tally_type;

   soc_pkg::sample_type set_samples [soc_pkg::MAX_SAMPLES];
   int unsigned set_size = 0;
   longint      set_sum = 0;
   longint      set_square_sum = 0;
   bit          set_overflow = 1'b0;
   tally_type   awaited_tallies [$];
   int          failure_total = 0;

   // exact test: (n*x - S)^2 > 9 * (n*Q - S^2)
   function automatic soc_pkg::count_type tally_outliers();
      logic signed [127:0] n, spread, bound, dev;
      soc_pkg::count_type  hits;
      int unsigned         i;
      hits = '0;
      if (set_size < 2)
         return '0;
      n      = set_size;
      spread = n * set_square_sum - set_sum * set_sum;
      if (spread <= 0)
         return '0;
      bound = 9 * spread;
      for (i = 0; i < set_size; i++) begin
         dev = n * set_samples[i] - set_sum;
         if (dev * dev > bound)
            hits++;
      end
      return hits;
   endfunction

   function automatic void clear_set();
      set_size       = 0;
      set_sum        = 0;
      set_square_sum = 0;
      set_overflow   = 1'b0;
   endfunction

   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         clear_set();
         awaited_tallies.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_tallies.size() == 0) begin
               $display("%0t: response with no set pending: expected none, actual %0d/%0b",
                        $time, rsp_mon.outlier_count, rsp_mon.overflowed);
               failure_total++;
            end else begin
               want = awaited_tallies.pop_front();
               if (rsp_mon.outlier_count !== want.outlier_count) begin
                  $display("%0t: outlier_count mismatch: expected %0d, actual %0d",
                           $time, want.outlier_count, rsp_mon.outlier_count);
                  failure_total++;
               end
               if (rsp_mon.overflowed !== want.overflowed) begin
                  $display("%0t: overflowed mismatch: expected %0b, actual %0b",
                           $time, want.overflowed, rsp_mon.overflowed);
                  failure_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (set_size < soc_pkg::MAX_SAMPLES) begin
               set_samples[set_size] = req_mon.sample;
               set_size++;
               set_sum        += longint'(req_mon.sample);
               set_square_sum += longint'(req_mon.sample) * longint'(req_mon.sample);
            end else begin
               set_overflow = 1'b1;
            end
            if (req_mon.last) begin
               want.outlier_count = tally_outliers();
               want.overflowed    = set_overflow;
               awaited_tallies.push_back(want);
               clear_set();
            end
         end
      end
      failures <= failure_total;
      pending  <= awaited_tallies.size();
   end

endmodule

### sim/sigma_outlier_counter_test.sv
// Testbench top for the sigma outlier counter: clock, reset, request and
// response pacing, directed and random sample sets, and the verdict.
// Depends on soc_pkg, soc_if, sigma_outlier_counter and its checker.
`timescale 1ns / 1ps

module sigma_outlier_counter_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_TAIL   = 60;
   localparam int DRAIN_CYCLES = 20;

   localparam soc_pkg::sample_type SAMPLE_TOP    = {1'b0, {(soc_pkg::SAMPLE_W-1){1'b1}}};
   localparam soc_pkg::sample_type SAMPLE_BOTTOM = {1'b1, {(soc_pkg::SAMPLE_W-1){1'b0}}};

   typedef enum int {SHAPE_UNIFORM, SHAPE_CLUSTER, SHAPE_FLAT, SHAPE_EXTREME} set_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   pending;
   int   cycles = 0;
   int   requests_sent = 0;
   bit   quiet = 1'b0;
   bit   calm_set = 1'b0;

   soc_req_if req_chan ();
   soc_rsp_if rsp_chan ();

   sigma_outlier_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sigma_outlier_counter_checker tally_check (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_chan),
      .rsp_mon  (rsp_chan),
      .failures (failures),
      .pending  (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : rsp_pacing
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0)
            stall_left--;
         else if (!quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 12);
         rsp_chan.ready <= (stall_left == 0) && !reset;
      end
   end

   task automatic push_sample(input soc_pkg::sample_type value, input logic is_last);
      if (!quiet && !calm_set && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      req_chan.last   <= is_last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      requests_sent++;
   endtask

   task automatic push_set(input int size, input set_shape_type shape,
                           input soc_pkg::sample_type anchor);
      int                  reach;
      int                  offset;
      int                  k;
      soc_pkg::sample_type value;
      reach    = 1 << $urandom_range(0, 12);
      calm_set = ($urandom_range(0, 3) == 0);
      for (k = 0; k < size; k++) begin
         case (shape)
            SHAPE_UNIFORM: value = soc_pkg::sample_type'($urandom);
            SHAPE_CLUSTER: begin
               offset = int'($urandom_range(0, 2 * reach)) - reach;
               // occasional spike far from the cluster
               if ($urandom_range(0, 11) == 0)
                  offset = ($urandom_range(0, 1) ? reach : -reach) * int'($urandom_range(4, 40));
               value = soc_pkg::sample_type'(int'(anchor) + offset);
            end
            SHAPE_FLAT: value = anchor;
            default: begin
               case ($urandom_range(0, 3))
                  0:       value = SAMPLE_TOP;
                  1:       value = SAMPLE_BOTTOM;
                  2:       value = '0;
                  default: value = '1;
               endcase
            end
         endcase
         push_sample(value, k == size - 1);
      end
   endtask

   initial begin
      int                  i;
      int                  size;
      int                  first_items;
      set_shape_type       shape;
      soc_pkg::sample_type anchor;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      req_chan.last   <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single sample, a pair of extremes, a flat pair
      push_sample(SAMPLE_TOP, 1'b1);
      push_sample(SAMPLE_BOTTOM, 1'b0);
      push_sample(SAMPLE_TOP, 1'b1);
      push_sample(SAMPLE_BOTTOM, 1'b0);
      push_sample(SAMPLE_BOTTOM, 1'b1);
      // one spike among zeros: exactly on the bound with ten, beyond it with eleven
      for (i = 0; i < 9; i++)
         push_sample('0, 1'b0);
      push_sample(SAMPLE_TOP, 1'b1);
      for (i = 0; i < 10; i++)
         push_sample('0, 1'b0);
      push_sample(SAMPLE_BOTTOM, 1'b1);

      first_items = requests_sent;
      while (requests_sent - first_items < RANDOM_ITEMS) begin
         quiet = (requests_sent - first_items >= RANDOM_ITEMS - QUIET_TAIL);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: shape = SHAPE_CLUSTER;
            10, 11, 12, 13, 14:           shape = SHAPE_UNIFORM;
            15, 16:                       shape = SHAPE_FLAT;
            default:                      shape = SHAPE_EXTREME;
         endcase
         case ($urandom_range(0, 19))
            0, 1:    size = 1;
            2:       size = $urandom_range(41, 150);
            default: size = $urandom_range(2, 40);
         endcase
         if (shape == SHAPE_FLAT)
            anchor = soc_pkg::sample_type'($urandom);
         else
            anchor = soc_pkg::sample_type'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
         push_set(size, shape, anchor);
      end

      quiet = 1'b1;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### sigma_outlier_counter.f
+incdir+rtl/core
rtl/core/soc_pkg.sv
rtl/core/soc_if.sv
rtl/core/soc_ram.sv
rtl/core/sigma_outlier_counter.sv
sim/sigma_outlier_counter_checker.sv
sim/sigma_outlier_counter_test.sv
